>>> rtl/dcmb_pkg.sv
// Package for the dual processor mailbox: request codes, control register
// bit positions and masks, the sync register masks and the interrupt pulse bit positions.
// No dependencies; the mailbox top level takes it by scoped names.
package dcmb_pkg;

    typedef enum logic [2:0] {
        REQ_SYNC_WR = 3'd0,
        REQ_SYNC_RD = 3'd1,
        REQ_CTRL_WR = 3'd2,
        REQ_SEND    = 3'd3,
        REQ_RECV    = 3'd4
    } req_t;

    // Control/status register bit positions.
    localparam int CTRL_SEND_EMPTY = 0;
    localparam int CTRL_SEND_FULL  = 1;
    localparam int CTRL_SEND_IRQEN = 2;
    localparam int CTRL_FLUSH      = 3;
    localparam int CTRL_RECV_EMPTY = 8;
    localparam int CTRL_RECV_FULL  = 9;
    localparam int CTRL_RECV_IRQEN = 10;
    localparam int CTRL_ERROR      = 14;
    localparam int CTRL_ENABLE     = 15;

    localparam logic [15:0] CTRL_WR_MASK = 16'h8404;
    localparam logic [15:0] CTRL_RESET   = 16'h0101;

    // Sync register: bits kept by the writer, and the readable bits.
    localparam logic [15:0] SYNC_WR_MASK = 16'h6F00;
    localparam logic [15:0] SYNC_RD_MASK = 16'h4F0F;
    localparam int          SYNC_IRQ_REQ = 13;
    localparam int          SYNC_IRQ_EN  = 14;

    // Interrupt pulse bit positions.
    localparam int IRQ_SYNC       = 0;
    localparam int IRQ_SEND_EMPTY = 1;
    localparam int IRQ_RECV_AVAIL = 2;

endpackage

>>> rtl/dual_cpu_mailbox_fifo.sv
// Dual processor mailbox: sync registers, two send FIFOs and control/status.
// Depends on dcmb_pkg for request codes and register bit definitions.
//
// Pipeline: an accepted transaction waits in the input register and moves
// on to the result register (m_tvalid) when that is empty or being taken.
// Throughput: one transaction per cycle unless m_tready stalls; the FIFO
// front word is read from the queue memory as the transaction is accepted,
// with a write bypass. Reset: rst_n clears sync, pointers, pipeline valids;
// control takes CTRL_RESET; queue memory has no reset, used only once written.
module dual_cpu_mailbox_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // write_data[31:0]
    input  logic [3:0]  s_tuser,  // req_type[2:0], side[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // read_data[31:0], ctrl_status[47:32],
                                  // irq_local[50:48], irq_remote[53:51], zero
);

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1  = CW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);
    localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

    logic [31:0] queue_mem [2][QUEUE_DEPTH];

    logic                in_valid_reg;
    dcmb_pkg::req_t      in_type_reg;
    logic                in_side_reg;
    logic [31:0]         in_data_reg;
    logic [31:0]         front_reg;

    logic [15:0]   sync_reg  [2];
    logic [15:0]   ctrl_reg  [2];
    logic [CW-1:0] count_reg [2];
    logic [HW-1:0] head_reg  [2];
    logic [31:0]   last_reg  [2];

    logic [15:0]   sync_next  [2];
    logic [15:0]   ctrl_next  [2];
    logic [CW-1:0] count_next [2];
    logic [HW-1:0] head_next  [2];
    logic [31:0]   last_next  [2];

    logic        out_valid_reg;
    logic [55:0] out_data_reg;

    logic accept;
    logic advance;

    logic [15:0]   ms, os, mc, oc, ms_n, os_n, mc_n, oc_n, old_c, d16;
    logic [CW-1:0] m_cnt, o_cnt, m_cnt_n, o_cnt_n;
    logic [HW-1:0] m_head, o_head, m_head_n, o_head_n;
    logic [31:0]   m_last, m_last_n, rd;
    logic [2:0]    il, ir;
    logic          wr_en;
    logic [HW-1:0] wr_slot;
    logic [SW-1:0] slot_sum;

    logic          rd_side;
    logic [HW-1:0] rd_slot;
    logic          collide;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        ms     = in_side_reg ? sync_reg[1]  : sync_reg[0];
        os     = in_side_reg ? sync_reg[0]  : sync_reg[1];
        mc     = in_side_reg ? ctrl_reg[1]  : ctrl_reg[0];
        oc     = in_side_reg ? ctrl_reg[0]  : ctrl_reg[1];
        m_cnt  = in_side_reg ? count_reg[1] : count_reg[0];
        o_cnt  = in_side_reg ? count_reg[0] : count_reg[1];
        m_head = in_side_reg ? head_reg[1]  : head_reg[0];
        o_head = in_side_reg ? head_reg[0]  : head_reg[1];
        m_last = in_side_reg ? last_reg[1]  : last_reg[0];
        d16    = in_data_reg[15:0];

        ms_n     = ms;
        os_n     = os;
        mc_n     = mc;
        oc_n     = oc;
        old_c    = mc;
        m_cnt_n  = m_cnt;
        o_cnt_n  = o_cnt;
        m_head_n = m_head;
        o_head_n = o_head;
        m_last_n = m_last;
        rd       = '0;
        il       = '0;
        ir       = '0;
        wr_en    = 1'b0;
        slot_sum = SW'(m_head) + SW'(m_cnt);
        if (slot_sum >= DEPTH_S)
        begin
            slot_sum = slot_sum - DEPTH_S;
        end
        wr_slot  = slot_sum[HW-1:0];

        case (in_type_reg)
            dcmb_pkg::REQ_SYNC_WR:
            begin
                ms_n = (ms & ~dcmb_pkg::SYNC_WR_MASK) | (d16 & dcmb_pkg::SYNC_WR_MASK);
                os_n = {os[15:4], d16[11:8]};
                if (ms_n[dcmb_pkg::SYNC_IRQ_REQ] && os_n[dcmb_pkg::SYNC_IRQ_EN])
                begin
                    ir[dcmb_pkg::IRQ_SYNC] = 1'b1;
                end
            end
            dcmb_pkg::REQ_SYNC_RD:
            begin
                rd = {16'h0000, ms & dcmb_pkg::SYNC_RD_MASK};
            end
            dcmb_pkg::REQ_CTRL_WR:
            begin
                mc_n = (old_c & ~dcmb_pkg::CTRL_WR_MASK) | (d16 & dcmb_pkg::CTRL_WR_MASK);
                if (d16[dcmb_pkg::CTRL_FLUSH])
                begin
                    m_cnt_n  = '0;
                    m_head_n = '0;
                    mc_n[dcmb_pkg::CTRL_SEND_EMPTY] = 1'b1;
                    mc_n[dcmb_pkg::CTRL_SEND_FULL]  = 1'b0;
                    oc_n[dcmb_pkg::CTRL_RECV_EMPTY] = 1'b1;
                    oc_n[dcmb_pkg::CTRL_RECV_FULL]  = 1'b0;
                    if (mc_n[dcmb_pkg::CTRL_SEND_IRQEN])
                    begin
                        il[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                    end
                end
                if (!old_c[dcmb_pkg::CTRL_SEND_IRQEN] && mc_n[dcmb_pkg::CTRL_SEND_EMPTY]
                    && d16[dcmb_pkg::CTRL_SEND_IRQEN])
                begin
                    il[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                end
                if (!old_c[dcmb_pkg::CTRL_RECV_IRQEN] && !mc_n[dcmb_pkg::CTRL_RECV_EMPTY]
                    && d16[dcmb_pkg::CTRL_RECV_IRQEN])
                begin
                    il[dcmb_pkg::IRQ_RECV_AVAIL] = 1'b1;
                end
                if (d16[dcmb_pkg::CTRL_ERROR])
                begin
                    mc_n[dcmb_pkg::CTRL_ERROR] = 1'b0;
                end
            end
            dcmb_pkg::REQ_SEND:
            begin
                if (mc[dcmb_pkg::CTRL_ENABLE])
                begin
                    if (m_cnt < DEPTH_C)
                    begin
                        wr_en   = 1'b1;
                        m_cnt_n = m_cnt + 1'b1;
                        if (m_cnt == '0)
                        begin
                            mc_n[dcmb_pkg::CTRL_SEND_EMPTY] = 1'b0;
                            oc_n[dcmb_pkg::CTRL_RECV_EMPTY] = 1'b0;
                            if (oc[dcmb_pkg::CTRL_RECV_IRQEN])
                            begin
                                ir[dcmb_pkg::IRQ_RECV_AVAIL] = 1'b1;
                            end
                        end
                        else if (m_cnt_n == DEPTH_C)
                        begin
                            mc_n[dcmb_pkg::CTRL_SEND_FULL] = 1'b1;
                            oc_n[dcmb_pkg::CTRL_RECV_FULL] = 1'b1;
                        end
                    end
                    else
                    begin
                        mc_n[dcmb_pkg::CTRL_ERROR] = 1'b1;
                    end
                end
            end
            dcmb_pkg::REQ_RECV:
            begin
                if (o_cnt != '0)
                begin
                    m_last_n = front_reg;
                    if (mc[dcmb_pkg::CTRL_ENABLE])
                    begin
                        o_head_n = (o_head == HEAD_LAST) ? '0 : o_head + 1'b1;
                        o_cnt_n  = o_cnt - 1'b1;
                        if (o_cnt_n == '0)
                        begin
                            oc_n[dcmb_pkg::CTRL_SEND_EMPTY] = 1'b1;
                            mc_n[dcmb_pkg::CTRL_RECV_EMPTY] = 1'b1;
                            if (oc[dcmb_pkg::CTRL_SEND_IRQEN])
                            begin
                                ir[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                            end
                        end
                        else if (o_cnt_n == DEPTH_M1)
                        begin
                            oc_n[dcmb_pkg::CTRL_SEND_FULL] = 1'b0;
                            mc_n[dcmb_pkg::CTRL_RECV_FULL] = 1'b0;
                        end
                    end
                end
                else
                begin
                    mc_n[dcmb_pkg::CTRL_ERROR] = 1'b1;
                end
                rd = m_last_n;
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    always_comb
    begin
        sync_next  = sync_reg;
        ctrl_next  = ctrl_reg;
        count_next = count_reg;
        head_next  = head_reg;
        last_next  = last_reg;
        if (advance)
        begin
            sync_next[0]  = in_side_reg ? os_n     : ms_n;
            sync_next[1]  = in_side_reg ? ms_n     : os_n;
            ctrl_next[0]  = in_side_reg ? oc_n     : mc_n;
            ctrl_next[1]  = in_side_reg ? mc_n     : oc_n;
            count_next[0] = in_side_reg ? o_cnt_n  : m_cnt_n;
            count_next[1] = in_side_reg ? m_cnt_n  : o_cnt_n;
            head_next[0]  = in_side_reg ? o_head_n : m_head_n;
            head_next[1]  = in_side_reg ? m_head_n : o_head_n;
            if (in_side_reg)
            begin
                last_next[1] = m_last_n;
            end
            else
            begin
                last_next[0] = m_last_n;
            end
        end
    end

    // The incoming transaction receives from the other side's queue.
    assign rd_side = ~s_tuser[3];
    assign rd_slot = rd_side ? head_next[1] : head_next[0];
    assign collide = advance && wr_en && (in_side_reg == rd_side) && (wr_slot == rd_slot);

    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            queue_mem[in_side_reg][wr_slot] <= in_data_reg;
        end
        if (accept)
        begin
            front_reg <= collide ? in_data_reg : queue_mem[rd_side][rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_type_reg <= dcmb_pkg::req_t'(s_tuser[2:0]);
            in_side_reg <= s_tuser[3];
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= {2'b00, ir, il, mc_n, rd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                sync_reg[i]  <= '0;
                ctrl_reg[i]  <= dcmb_pkg::CTRL_RESET;
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                last_reg[i]  <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            sync_reg  <= sync_next;
            ctrl_reg  <= ctrl_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> sim/tb_dual_cpu_mailbox_fifo.sv
// Self-checking testbench for the dual processor mailbox: directed and random bus traffic
// against a cycle-free predictor of the sync registers, send FIFOs and control/status.
// Depends on dcmb_pkg and dual_cpu_mailbox_fifo.
module tb_dual_cpu_mailbox_fifo;

    localparam int          MBOX_DEPTH      = 16;
    localparam int          RANDOM_ITEMS    = 420;
    localparam int          MAX_REPORTS     = 30;
    localparam logic [2:0]  REQ_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] ctrl_status;
        logic [2:0]  irq_local;
        logic [2:0]  irq_remote;
    } mbox_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    logic [15:0] sync_val [2];
    logic [15:0] ctrl_val [2];
    logic [31:0] queue_mem [2][MBOX_DEPTH];
    int          queue_fill [2];
    int          queue_front [2];
    logic [31:0] recv_word [2];

    mbox_result_t pending_results [$];
    int           error_count;
    bit           no_idle;

    dual_cpu_mailbox_fifo #(
        .QUEUE_DEPTH(MBOX_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic clear_model();
        for (int i = 0; i < 2; i++)
        begin
            sync_val[i]    = '0;
            ctrl_val[i]    = dcmb_pkg::CTRL_RESET;
            queue_fill[i]  = 0;
            queue_front[i] = 0;
            recv_word[i]   = '0;
        end
    endtask

    function automatic mbox_result_t mailbox_access(input logic [2:0] req, input logic sd,
                                                    input logic [31:0] wdata);
        mbox_result_t res;
        logic         od;
        logic [15:0]  d16;
        logic [15:0]  prior;
        int           slot;
        res   = '0;
        od    = ~sd;
        d16   = wdata[15:0];
        case (req)
            dcmb_pkg::REQ_SYNC_WR:
            begin
                sync_val[sd] = (sync_val[sd] & ~dcmb_pkg::SYNC_WR_MASK)
                               | (d16 & dcmb_pkg::SYNC_WR_MASK);
                sync_val[od][3:0] = d16[11:8];
                if (sync_val[sd][dcmb_pkg::SYNC_IRQ_REQ] && sync_val[od][dcmb_pkg::SYNC_IRQ_EN])
                    res.irq_remote[dcmb_pkg::IRQ_SYNC] = 1'b1;
            end
            dcmb_pkg::REQ_SYNC_RD:
            begin
                res.read_data = {16'h0, sync_val[sd] & dcmb_pkg::SYNC_RD_MASK};
            end
            dcmb_pkg::REQ_CTRL_WR:
            begin
                prior = ctrl_val[sd];
                ctrl_val[sd] = (prior & ~dcmb_pkg::CTRL_WR_MASK) | (d16 & dcmb_pkg::CTRL_WR_MASK);
                if (d16[dcmb_pkg::CTRL_FLUSH])
                begin
                    queue_fill[sd]  = 0;
                    queue_front[sd] = 0;
                    ctrl_val[sd][dcmb_pkg::CTRL_SEND_EMPTY] = 1'b1;
                    ctrl_val[sd][dcmb_pkg::CTRL_SEND_FULL]  = 1'b0;
                    ctrl_val[od][dcmb_pkg::CTRL_RECV_EMPTY] = 1'b1;
                    ctrl_val[od][dcmb_pkg::CTRL_RECV_FULL]  = 1'b0;
                    if (ctrl_val[sd][dcmb_pkg::CTRL_SEND_IRQEN])
                        res.irq_local[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                end
                if (!prior[dcmb_pkg::CTRL_SEND_IRQEN] && ctrl_val[sd][dcmb_pkg::CTRL_SEND_EMPTY]
                    && d16[dcmb_pkg::CTRL_SEND_IRQEN])
                    res.irq_local[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                if (!prior[dcmb_pkg::CTRL_RECV_IRQEN] && !ctrl_val[sd][dcmb_pkg::CTRL_RECV_EMPTY]
                    && d16[dcmb_pkg::CTRL_RECV_IRQEN])
                    res.irq_local[dcmb_pkg::IRQ_RECV_AVAIL] = 1'b1;
                if (d16[dcmb_pkg::CTRL_ERROR])
                    ctrl_val[sd][dcmb_pkg::CTRL_ERROR] = 1'b0;
            end
            dcmb_pkg::REQ_SEND:
            begin
                if (ctrl_val[sd][dcmb_pkg::CTRL_ENABLE])
                begin
                    if (queue_fill[sd] < MBOX_DEPTH)
                    begin
                        slot = (queue_front[sd] + queue_fill[sd]) % MBOX_DEPTH;
                        queue_mem[sd][slot] = wdata;
                        queue_fill[sd]++;
                        if (queue_fill[sd] == 1)
                        begin
                            ctrl_val[sd][dcmb_pkg::CTRL_SEND_EMPTY] = 1'b0;
                            ctrl_val[od][dcmb_pkg::CTRL_RECV_EMPTY] = 1'b0;
                            if (ctrl_val[od][dcmb_pkg::CTRL_RECV_IRQEN])
                                res.irq_remote[dcmb_pkg::IRQ_RECV_AVAIL] = 1'b1;
                        end
                        else if (queue_fill[sd] == MBOX_DEPTH)
                        begin
                            ctrl_val[sd][dcmb_pkg::CTRL_SEND_FULL] = 1'b1;
                            ctrl_val[od][dcmb_pkg::CTRL_RECV_FULL] = 1'b1;
                        end
                    end
                    else
                    begin
                        ctrl_val[sd][dcmb_pkg::CTRL_ERROR] = 1'b1;
                    end
                end
            end
            dcmb_pkg::REQ_RECV:
            begin
                if (queue_fill[od] != 0)
                begin
                    recv_word[sd] = queue_mem[od][queue_front[od]];
                    if (ctrl_val[sd][dcmb_pkg::CTRL_ENABLE])
                    begin
                        queue_front[od] = (queue_front[od] + 1) % MBOX_DEPTH;
                        queue_fill[od]--;
                        if (queue_fill[od] == 0)
                        begin
                            ctrl_val[od][dcmb_pkg::CTRL_SEND_EMPTY] = 1'b1;
                            ctrl_val[sd][dcmb_pkg::CTRL_RECV_EMPTY] = 1'b1;
                            if (ctrl_val[od][dcmb_pkg::CTRL_SEND_IRQEN])
                                res.irq_remote[dcmb_pkg::IRQ_SEND_EMPTY] = 1'b1;
                        end
                        else if (queue_fill[od] == MBOX_DEPTH - 1)
                        begin
                            ctrl_val[od][dcmb_pkg::CTRL_SEND_FULL] = 1'b0;
                            ctrl_val[sd][dcmb_pkg::CTRL_RECV_FULL] = 1'b0;
                        end
                    end
                end
                else
                begin
                    ctrl_val[sd][dcmb_pkg::CTRL_ERROR] = 1'b1;
                end
                res.read_data = recv_word[sd];
            end
            default:
            begin
            end
        endcase
        res.ctrl_status = ctrl_val[sd];
        return res;
    endfunction

    task automatic send_access(input logic [2:0] req, input logic sd, input logic [31:0] wdata);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= wdata;
        s_tuser  <= {sd, req};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(mailbox_access(req, sd, wdata));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic report_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        mbox_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("read_data", want.read_data, m_tdata[31:0]);
                report_field("ctrl_status", {16'h0, want.ctrl_status}, {16'h0, m_tdata[47:32]});
                report_field("irq_local", {29'h0, want.irq_local}, {29'h0, m_tdata[50:48]});
                report_field("irq_remote", {29'h0, want.irq_remote}, {29'h0, m_tdata[53:51]});
            end
        end
    end

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic test_sync_doorbell();
        send_access(dcmb_pkg::REQ_SYNC_WR, 1'b0, 32'hFFFF_FFFF);
        send_access(dcmb_pkg::REQ_SYNC_WR, 1'b1, 32'h0000_6F00);
        send_access(dcmb_pkg::REQ_SYNC_RD, 1'b0, 32'h0000_0000);
    endtask

    task automatic test_fifo_fill_overflow();
        send_access(dcmb_pkg::REQ_CTRL_WR, 1'b0, 32'h0000_8404);
        send_access(dcmb_pkg::REQ_SEND, 1'b0, 32'hFFFF_FFFF);
        send_access(dcmb_pkg::REQ_SEND, 1'b0, 32'h0000_0000);
        for (int i = 0; i < MBOX_DEPTH - 1; i++)
            send_access(dcmb_pkg::REQ_SEND, 1'b0, $urandom());
    endtask

    task automatic test_enable_edges_and_flush();
        send_access(dcmb_pkg::REQ_RECV, 1'b1, 32'h0);
        send_access(dcmb_pkg::REQ_CTRL_WR, 1'b1, 32'h0000_8400);
        send_access(dcmb_pkg::REQ_RECV, 1'b1, 32'h0);
        send_access(dcmb_pkg::REQ_CTRL_WR, 1'b0, 32'h0000_C40C);
    endtask

    task automatic test_errors_and_unused();
        send_access(dcmb_pkg::REQ_RECV, 1'b1, 32'h0);
        send_access(dcmb_pkg::REQ_CTRL_WR, 1'b1, 32'h0000_4000);
        send_access(dcmb_pkg::REQ_SEND, 1'b1, 32'hA5A5_5A5A);
        send_access(REQ_UNUSED_LAST, 1'b0, 32'hFFFF_FFFF);
    endtask

    function automatic logic [31:0] ctrl_word();
        logic [31:0] w;
        w = $urandom();
        w[dcmb_pkg::CTRL_ENABLE] = ($urandom_range(0, 7) != 0);
        w[dcmb_pkg::CTRL_FLUSH]  = ($urandom_range(0, 5) == 0);
        return w;
    endfunction

    task automatic test_random_traffic();
        int   issued;
        int   len;
        int   pick;
        logic sd;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 9);
            sd      = 1'($urandom_range(0, 1));
            len     = $urandom_range(1, 20);
            if (pick <= 2)
            begin
                for (int i = 0; i < len; i++)
                    send_access(dcmb_pkg::REQ_SEND, sd, $urandom());
            end
            else if (pick <= 5)
            begin
                for (int i = 0; i < len; i++)
                    send_access(dcmb_pkg::REQ_RECV, sd, $urandom());
            end
            else if (pick == 6)
            begin
                len = 1;
                send_access(dcmb_pkg::REQ_CTRL_WR, sd, ctrl_word());
            end
            else if (pick == 7)
            begin
                len = 2;
                send_access(dcmb_pkg::REQ_SYNC_WR, sd, $urandom());
                send_access(dcmb_pkg::REQ_SYNC_RD, ~sd, $urandom());
            end
            else if (pick == 8)
            begin
                len = 10;
                for (int i = 0; i < len; i++)
                    send_access($urandom_range(0, 1) ? dcmb_pkg::REQ_SEND : dcmb_pkg::REQ_RECV,
                                1'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                len = 5;
                for (int i = 0; i < len; i++)
                    send_access(3'($urandom_range(0, REQ_UNUSED_LAST)),
                                1'($urandom_range(0, 1)), $urandom());
            end
            issued += len;
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        error_count = 0;
        no_idle     = 1'b0;
        clear_model();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_sync_doorbell();
        wait_drained();
        no_idle = 1'b1;
        test_fifo_fill_overflow();
        wait_drained();
        no_idle = 1'b0;
        test_enable_edges_and_flush();
        wait_drained();
        test_errors_and_unused();
        wait_drained();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/dcmb_pkg.sv
rtl/dual_cpu_mailbox_fifo.sv
sim/tb_dual_cpu_mailbox_fifo.sv
